FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KGR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KGR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/k_grp_pkg.sv
`timescale 1ns / 1ps
package k_grp_pkg;

	localparam int DATA_W        = 32;
	localparam int GS_W          = 5;
	// count width covers the largest supported group (64)
	localparam int CNT_W         = 7;
	localparam int MAX_GROUP_DEF = 16;
	localparam logic [GS_W-1:0] GS_RESET = 5'd2;

	// one drain job handed from front to back
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             rev;
		logic             seq_end;
	} cmd_t;

endpackage

FILE: sv/k_grp_ram.sv
`timescale 1ns / 1ps
module k_grp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/k_grp_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module k_grp_front
	import k_grp_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF,
	parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [GS_W-1:0]   cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] in_data,
	input  logic              in_last,
	input  logic              bank_done,
	output logic              wr_en,
	output logic [IW:0]       wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic              push,
	output cmd_t              push_cmd
);

	logic [GS_W-1:0]  group_size_q;
	logic [CNT_W-1:0] fill_q;
	logic             wbank_q;
	logic [1:0]       pending_q;
	logic [CNT_W-1:0] gs_ext;
	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] n_cnt;
	logic             accept;
	logic             full_grp;

	// zero acts as one, anything above the buffer size saturates
	always_comb begin
		gs_ext = CNT_W'(group_size_q);
		if (gs_ext == '0) begin
			k_eff = CNT_W'(1);
		end else if (gs_ext > CNT_W'(MAX_GROUP)) begin
			k_eff = CNT_W'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	// both banks hold groups not yet read out: hold the input
	assign in_stall = (pending_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	assign n_cnt    = fill_q + CNT_W'(1);
	assign full_grp = (n_cnt >= k_eff);

	assign wr_en   = accept;
	assign wr_addr = {wbank_q, fill_q[IW-1:0]};
	assign wr_data = in_data;

	assign push             = accept && (full_grp || in_last);
	assign push_cmd.bank    = wbank_q;
	assign push_cmd.count   = n_cnt;
	assign push_cmd.rev     = full_grp;
	assign push_cmd.seq_end = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GS_RESET;
			fill_q       <= '0;
			wbank_q      <= 1'b0;
			pending_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				group_size_q <= cfg_wr_data;
			end
			if (accept) begin
				if (push) begin
					fill_q  <= '0;
					wbank_q <= !wbank_q;
				end else begin
					fill_q <= n_cnt;
				end
			end
			if (push && !bank_done) begin
				pending_q <= pending_q + 2'd1;
			end else if (!push && bank_done) begin
				pending_q <= pending_q - 2'd1;
			end
		end
	end

	`KGR_ASSERT_NOW(a_fill_in_range, clk, arst_n, 1'b1, fill_q < CNT_W'(MAX_GROUP), "fill count reached buffer size")
	`KGR_ASSERT_NOW(a_done_has_pending, clk, arst_n, bank_done, pending_q != 2'd0, "bank released with none pending")
	`KGR_ASSERT_NOW(a_pending_bound, clk, arst_n, 1'b1, pending_q != 2'd3, "pending bank count overflow")

endmodule

FILE: sv/k_grp_cmdq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module k_grp_cmdq
	import k_grp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`KGR_ASSERT_NOW(a_no_overflow, clk, arst_n, push && !pop, cnt_q != 2'd2, "queue overflow")
	`KGR_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, cnt_q != 2'd0, "queue underflow")

endmodule

FILE: sv/k_grp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module k_grp_back
	import k_grp_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF,
	parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  cmd_t                     head_cmd,
	output logic                     pop,
	output logic                     bank_done,
	output logic                     rd_en,
	output logic [IW:0]              rd_addr,
	input  logic [DATA_W-1:0]        rd_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     run_last,
	output logic                     seq_end
);

	cmd_t             cmd_q;
	logic             active_q;
	logic [CNT_W-1:0] idx_q;
	logic             valid_s1;
	logic             run_last_s1;
	logic             seq_end_s1;
	logic             out_valid_q;
	logic             run_last_q;
	logic             seq_end_q;
	logic [DATA_W-1:0] out_value_q;
	logic             move_s1;
	logic             issue;
	logic             last_idx;
	logic [CNT_W-1:0] sel;

	assign move_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign issue     = active_q && (!valid_s1 || move_s1);
	assign last_idx  = (idx_q == cmd_q.count - CNT_W'(1));
	assign bank_done = issue && last_idx;
	assign pop       = head_valid && (!active_q || bank_done);

	// a full group reads newest first, a tail reads oldest first
	assign sel     = cmd_q.rev ? (cmd_q.count - CNT_W'(1) - idx_q) : idx_q;
	assign rd_en   = issue;
	assign rd_addr = {cmd_q.bank, sel[IW-1:0]};

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign run_last  = run_last_q;
	assign seq_end   = seq_end_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (issue) begin
			run_last_s1 <= last_idx;
			seq_end_s1  <= last_idx && cmd_q.seq_end;
		end
		if (move_s1) begin
			out_value_q <= rd_data;
			run_last_q  <= run_last_s1;
			seq_end_q   <= seq_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (bank_done) begin
				active_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`KGR_ASSERT_NEXT(a_rdata_held, clk, arst_n, valid_s1 && !move_s1, $stable(rd_data), "read data lost while held")
	`KGR_ASSERT_NOW(a_issue_in_range, clk, arst_n, issue, idx_q < cmd_q.count, "read index past job end")

endmodule

FILE: sv/k_group_reverser.sv
`timescale 1ns / 1ps
// Reverses a stream of signed 32-bit words in groups of group_size (1..MAX_GROUP; zero acts as
// one, larger values saturate). Each accepted word is written into one of two buffer banks. When
// a group fills, the whole group is sent out newest first; when the word flagged seq_last ends a
// partial group, the words held so far go out in their original order. run_last marks the last
// word of each run and seq_end the last word caused by a seq_last word. The front takes one word
// per cycle unless in_stall is high, and the back sends one word per cycle unless out_stall holds
// it. The input holds while both banks hold groups still being read out. When the back finds the
// job queue empty it goes idle and takes the next job before it reads again, so the input can
// hold even with the output never stalled. Output stalls reach the input the same way, once both
// banks are waiting. After the word that closed a group, the first word of its run passes the
// job queue, the job register of the back, the RAM read and the output register before it leaves.
// A write to group_size takes effect from the next word and keeps the buffered words.
module k_group_reverser
	import k_grp_pkg::*;
#(
	parameter int MAX_GROUP = MAX_GROUP_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [GS_W-1:0]          cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic                     seq_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     run_last,
	output logic                     seq_end
);

	// index width within one bank; the bank bit sits on top
	localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic              wr_en;
	logic [IW:0]       wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [IW:0]       rd_addr;
	logic [DATA_W-1:0] rd_data;
	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	logic              head_valid;
	cmd_t              head_cmd;
	logic              bank_done;

	// front: hold config, fill the current bank, classify each word
	k_grp_front #(
		.MAX_GROUP (MAX_GROUP),
		.IW        (IW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (item_value),
		.in_last     (seq_last),
		.bank_done   (bank_done),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// two banks of MAX_GROUP words each
	k_grp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (2 ** (IW + 1))
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// drain jobs waiting between front and back
	k_grp_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// back: read a bank out in the chosen order through the output register
	k_grp_back #(
		.MAX_GROUP (MAX_GROUP),
		.IW        (IW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.bank_done  (bank_done),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.run_last   (run_last),
		.seq_end    (seq_end)
	);

endmodule

FILE: test/kgr_check_pkg.sv
`timescale 1ns / 1ps
package kgr_check_pkg;
	import k_grp_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              run_last;
		logic              seq_end;
	} reordered_word_t;

	// Track buffered words and the words the block owes us.
	class group_reverse_tracker;
		logic [DATA_W-1:0] held[MAX_GROUP_DEF];
		int unsigned       held_count;
		logic [GS_W-1:0]   group_size;
		reordered_word_t   due_words[$];
		int unsigned       words_taken;
		int unsigned       words_matched;
		int unsigned       reversed_runs;
		int unsigned       in_order_runs;
		int unsigned       seq_ends;

		function new();
			held_count    = 0;
			group_size    = GS_RESET;
			words_taken   = 0;
			words_matched = 0;
			reversed_runs = 0;
			in_order_runs = 0;
			seq_ends      = 0;
		endfunction

		function void set_group_size(logic [GS_W-1:0] v);
			group_size = v;
		endfunction

		// Zero acts as one, anything past the buffer depth saturates.
		function int unsigned span();
			if (group_size == 0)
				return 1;
			if (group_size > MAX_GROUP_DEF)
				return MAX_GROUP_DEF;
			return group_size;
		endfunction

		function void take_word(logic [DATA_W-1:0] v, logic is_last);
			int unsigned k;
			int unsigned n;
			reordered_word_t w;
			k = span();
			held[held_count] = v;
			held_count++;
			n = held_count;
			if (n < k && !is_last)
				return;
			for (int unsigned i = 0; i < n; i++) begin
				w.value    = (n >= k) ? held[n - 1 - i] : held[i];
				w.run_last = (i == n - 1);
				w.seq_end  = is_last && (i == n - 1);
				due_words.push_back(w);
			end
			if (n >= k)
				reversed_runs++;
			else
				in_order_runs++;
			if (is_last)
				seq_ends++;
			held_count = 0;
			words_taken += n;
		endfunction

		function int match_word(logic [DATA_W-1:0] v, logic rl, logic se);
			reordered_word_t want;
			int errs;
			errs = 0;
			if (due_words.size() == 0) begin
				$error("unexpected word: out_value=%0d run_last=%0b seq_end=%0b",
					$signed(v), rl, se);
				return 1;
			end
			want = due_words.pop_front();
			words_matched++;
			if (want.value !== v) begin
				$error("out_value: expected %0d, got %0d", $signed(want.value), $signed(v));
				errs++;
			end
			if (want.run_last !== rl) begin
				$error("run_last: expected %0b, got %0b", want.run_last, rl);
				errs++;
			end
			if (want.seq_end !== se) begin
				$error("seq_end: expected %0b, got %0b", want.seq_end, se);
				errs++;
			end
			return errs;
		endfunction

		function int unsigned outstanding();
			return due_words.size();
		endfunction
	endclass

endpackage

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import k_grp_pkg::*;
	import kgr_check_pkg::*;

	// Cycles to let pass before a register write, once every owed word is out: margin for the bank handover.
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_WORDS  = 300;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [GS_W-1:0]          cfg_wr_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] item_value = '0;
	logic                     seq_last = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DATA_W-1:0] out_value;
	logic                     run_last;
	logic                     seq_end;

	group_reverse_tracker book = new();
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned phases = 0;

	// Calm stretches switch off idling on both sides for a while.
	logic        calm = 1'b0;
	int unsigned calm_left = 0;
	int unsigned stall_left = 0;

	always #2 clk = ~clk;

	k_group_reverser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.item_value (item_value),
		.seq_last   (seq_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.run_last   (run_last),
		.seq_end    (seq_end)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Favor the extremes of the signed range, otherwise any 32-bit pattern.
	function automatic logic [DATA_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 19);
		case (r)
			0: return {1'b1, {(DATA_W-1){1'b0}}};
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// Mostly whole groups per sequence, some ragged ones.
	function automatic int unsigned pick_seq_len(int unsigned k);
		if ($urandom_range(0, 9) < 7)
			return k * $urandom_range(1, 3);
		return $urandom_range(1, 3 * k);
	endfunction

	function automatic logic [GS_W-1:0] pick_group_size();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(1, 6);
		return $urandom_range(0, 31);
	endfunction

	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm <= ($urandom_range(0, 3) == 0);
			calm_left = $urandom_range(50, 200);
		end else begin
			calm_left--;
		end
	end

	// Drive the output stall: hold a picked stall for its length, then pick again.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = idle_len();
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Check every word that leaves the block against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mismatches += book.match_word(out_value, run_last, seq_end);
	end

	// Offer one word, hold it until accepted, then record it.
	task automatic push_word(logic [DATA_W-1:0] v, logic is_last);
		int unsigned gap;
		gap = calm ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		item_value <= v;
		seq_last   <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.take_word(v, is_last);
		words_sent++;
	endtask

	// Drop valid, wait until every owed word is out, then let the pipe drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_group_size(logic [GS_W-1:0] v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.set_group_size(v);
		phases++;
	endtask

	initial begin
		logic [GS_W-1:0] fixed_sizes[5];
		logic [GS_W-1:0] gs;
		int unsigned     random_sent;
		int unsigned     k;
		int unsigned     phase_len;
		int unsigned     seq_pos;
		int unsigned     seq_len;
		int unsigned     phase_idx;
		logic            is_last;
		logic            final_phase;

		fixed_sizes = '{5'd31, 5'd16, 5'd1, 5'd17, 5'd3};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset group size of two: extremes, a full group on the sequence end,
		// a lone word ending a sequence, and a group followed by a partial one.
		push_word(32'h8000_0000, 1'b0);
		push_word(32'h7fff_ffff, 1'b0);
		push_word(32'hffff_ffff, 1'b0);
		push_word(32'h0000_0000, 1'b1);
		push_word(32'h1234_5678, 1'b1);
		push_word(32'd5, 1'b0);
		push_word(32'd6, 1'b0);
		push_word(32'd7, 1'b1);

		// Buffer three words under a size of five, which yields nothing, then
		// lower the size to two: the next word flushes all four reversed.
		write_group_size(5'd5);
		push_word(32'hdead_beef, 1'b0);
		push_word(32'h0bad_f00d, 1'b0);
		push_word(32'h5555_aaaa, 1'b0);
		write_group_size(5'd2);
		push_word(32'haaaa_5555, 1'b0);

		// Size zero behaves as one: every word goes out on its own.
		write_group_size(5'd0);
		push_word(32'h0000_0001, 1'b0);
		push_word(32'hfedc_ba98, 1'b1);

		// Random phases: a new group size each, sequences of random content.
		// A phase may stop mid-group so the next size change lands on
		// buffered words.
		random_sent = 0;
		phase_idx = 0;
		while (random_sent < RANDOM_WORDS) begin
			gs = (phase_idx < 5) ? fixed_sizes[phase_idx] : pick_group_size();
			write_group_size(gs);
			k = book.span();
			phase_len = $urandom_range(20, 50);
			final_phase = (random_sent + phase_len >= RANDOM_WORDS);
			seq_pos = 0;
			seq_len = pick_seq_len(k);
			for (int unsigned i = 0; i < phase_len; i++) begin
				seq_pos++;
				is_last = (seq_pos == seq_len) || (final_phase && i == phase_len - 1);
				push_word(pick_value(), is_last);
				if (is_last) begin
					seq_pos = 0;
					seq_len = pick_seq_len(k);
				end
			end
			random_sent += phase_len;
			phase_idx++;
		end

		// Drain and give stray words a chance to show up.
		in_valid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input words, %0d result words checked in %0d reversed runs",
			words_sent, book.words_matched, book.reversed_runs);
		$display("and %0d in-order tails, %0d sequence ends, across %0d group size settings",
			book.in_order_runs, book.seq_ends, phases);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/k_grp_pkg.sv
sv/k_grp_ram.sv
sv/k_grp_front.sv
sv/k_grp_cmdq.sv
sv/k_grp_back.sv
sv/k_group_reverser.sv
test/kgr_check_pkg.sv
test/tb.sv
